### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/e2cp_pkg.sv
// Package: payload types, CORDIC constants and fixed-point helpers.
`default_nettype none
package e2cp_pkg;
  localparam int AngleBits   = 16;
  localparam int FracBits    = 14;
  localparam int MBits       = FracBits + 2;
  localparam int CordicSteps = 30;
  localparam int AccBits     = 40;
  localparam int ZBits       = 34;
  localparam int QBits       = 32;
  localparam int PBits       = 64;
  localparam logic signed [AccBits-1:0] XInit = 40'sd2608131496;
  localparam logic signed [QBits-1:0]   OneQ30 = 32'sh4000_0000;

  typedef struct packed {
    logic signed [AngleBits-1:0] roll_angle;
    logic signed [AngleBits-1:0] pitch_angle;
    logic signed [AngleBits-1:0] yaw_angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_req_t;

  typedef struct packed {
    logic signed [MBits-1:0] m_r0c0;
    logic signed [MBits-1:0] m_r0c1;
    logic signed [MBits-1:0] m_r0c2;
    logic signed [31:0] t_out_0;
    logic signed [MBits-1:0] m_r1c0;
    logic signed [MBits-1:0] m_r1c1;
    logic signed [MBits-1:0] m_r1c2;
    logic signed [31:0] t_out_1;
    logic signed [MBits-1:0] m_r2c0;
    logic signed [MBits-1:0] m_r2c1;
    logic signed [MBits-1:0] m_r2c2;
    logic signed [31:0] t_out_2;
  } out_req_t;

  // one rotator lane: x, y, residual angle
  typedef struct packed {
    logic signed [AccBits-1:0] x;
    logic signed [AccBits-1:0] y;
    logic signed [ZBits-1:0]   z;
  } rot_t;

  typedef struct packed {
    rot_t r;
    rot_t p;
    rot_t w;
    logic [1:0] qr;
    logic [1:0] qp;
    logic [1:0] qw;
  } lanes_t;

  function automatic logic signed [ZBits-1:0] atan_f(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000; 5'd1:  a = 32'h12E4051D; 5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4; 5'd4:  a = 32'h028B0D43; 5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E; 5'd7:  a = 32'h00517C55; 5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F; 5'd10: a = 32'h000A2F98; 5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6; 5'd13: a = 32'h000145F3; 5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C; 5'd16: a = 32'h000028BE; 5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F; 5'd19: a = 32'h00000517; 5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145; 5'd22: a = 32'h000000A2; 5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000028; 5'd25: a = 32'h00000014; 5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005; 5'd28: a = 32'h00000002; 5'd29: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return $signed({2'b00, a});
  endfunction

  // one rotation step at a fixed shift
  function automatic rot_t rot_step(input rot_t v, input logic [4:0] i);
    rot_t o;
    logic signed [AccBits-1:0] dx;
    logic signed [AccBits-1:0] dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (!v.z[ZBits-1]) begin
      o.x = v.x - dx; o.y = v.y + dy; o.z = v.z - atan_f(i);
    end else begin
      o.x = v.x + dx; o.y = v.y - dy; o.z = v.z + atan_f(i);
    end
    return o;
  endfunction

  // angle to quadrant and starting vector
  function automatic rot_t rot_init(input logic [AngleBits-1:0] a, output logic [1:0] q);
    rot_t o;
    logic [31:0] ph;
    logic [31:0] ur;
    ph = {a, {(32-AngleBits){1'b0}}};
    q  = 2'((ph + 32'h2000_0000) >> 30);
    ur = ph - {q, 30'd0};
    o.x = XInit;
    o.y = '0;
    o.z = ZBits'($signed(ur));
    return o;
  endfunction

  // round Q.32 to Q1.30 and clamp to +-1
  function automatic logic signed [QBits-1:0] cord_out(input logic signed [AccBits-1:0] v);
    logic signed [AccBits-1:0] t;
    t = (v + 40'sd2) >>> 2;
    if (t > 40'sd1073741824) return OneQ30;
    if (t < -40'sd1073741824) return -OneQ30;
    return t[QBits-1:0];
  endfunction

  // round a Q60 sum to Q1.FracBits and clamp
  function automatic logic signed [MBits-1:0] entry_out(input logic signed [PBits+1:0] v);
    logic signed [PBits+1:0] t;
    logic signed [PBits+1:0] lim;
    lim = (PBits+2)'(1) <<< FracBits;
    t = (v + ((PBits+2)'(1) <<< (59 - FracBits))) >>> (60 - FracBits);
    if (t > lim) return lim[MBits-1:0];
    if (t < -lim) return MBits'(-lim);
    return t[MBits-1:0];
  endfunction
endpackage
`default_nettype wire

### rtl/e2cp_cell.sv
// One CORDIC cell: a fixed-shift rotation step on three lanes plus payload carry.
`default_nettype none
module e2cp_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [4:0]       step_i,
  input  wire logic             valid_i,
  input  wire e2cp_pkg::lanes_t lanes_i,
  input  wire logic [95:0]      pos_i,
  input  wire logic             adv_i,
  output logic                  valid_o,
  output e2cp_pkg::lanes_t      lanes_o,
  output logic [95:0]           pos_o
);
  import e2cp_pkg::*;
  logic valid_q;
  lanes_t lanes_q, lanes_d;
  logic [95:0] pos_q;

  always_comb begin
    lanes_d = lanes_i;
    lanes_d.r = rot_step(lanes_i.r, step_i);
    lanes_d.p = rot_step(lanes_i.p, step_i);
    lanes_d.w = rot_step(lanes_i.w, step_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lanes_q <= lanes_d;
      pos_q   <= pos_i;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;
  assign pos_o   = pos_q;
endmodule
`default_nettype wire

### rtl/e2cp_mat.sv
// Matrix stage: products of sines and cosines into nine entries, position reorder.
`default_nettype none
module e2cp_mat (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire e2cp_pkg::lanes_t  lanes_i,
  input  wire logic [95:0]       pos_i,
  output logic                   valid_o,
  output e2cp_pkg::out_req_t     res_o
);
  import e2cp_pkg::*;
  typedef logic signed [QBits-1:0] q_t;
  typedef logic signed [PBits-1:0] p_t;

  // stage 1: trig values
  logic [2:0] v_q;
  q_t cr_q, sr_q, cp_q, sp_q, cy_q, sy_q;
  q_t cr_d, sr_d, cp_d, sp_d, cy_d, sy_d;
  logic [95:0] pos1_q, pos2_q;

  function automatic void quad(input logic [1:0] q, input q_t cx, input q_t sx,
                               output q_t c, output q_t s);
    case (q)
      2'd0: begin c = cx;  s = sx;  end
      2'd1: begin c = -sx; s = cx;  end
      2'd2: begin c = -cx; s = -sx; end
      default: begin c = sx; s = -cx; end
    endcase
  endfunction

  always_comb begin
    quad(lanes_i.qr, cord_out(lanes_i.r.x), cord_out(lanes_i.r.y), cr_d, sr_d);
    quad(lanes_i.qp, cord_out(lanes_i.p.x), cord_out(lanes_i.p.y), cp_d, sp_d);
    quad(lanes_i.qw, cord_out(lanes_i.w.x), cord_out(lanes_i.w.y), cy_d, sy_d);
  end

  // stage 2: rounded triple-product factors, passthrough of trig
  q_t sysp_q, cysp_q, cr2_q, sr2_q, cp2_q, sp2_q, cy2_q, sy2_q;
  p_t prod_ys, prod_yc;
  assign prod_ys = p_t'(sy_q) * p_t'(sp_q);
  assign prod_yc = p_t'(cy_q) * p_t'(sp_q);

  function automatic q_t rnd30(input p_t v);
    p_t t;
    t = (v + (p_t'(1) <<< 29)) >>> 30;
    return t[QBits-1:0];
  endfunction

  // stage 3: sums, rounding
  typedef logic signed [PBits+1:0] s_t;
  out_req_t res_q;
  out_req_t res_d;
  logic [31:0] nz;
  s_t pos_one;

  always_comb begin
    nz = (pos2_q[31:0] == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - pos2_q[31:0]);
    pos_one = s_t'(sp2_q) <<< 30;
    res_d.m_r0c0 = entry_out(s_t'(p_t'(cy2_q) * p_t'(cr2_q)) - s_t'(p_t'(sysp_q) * p_t'(sr2_q)));
    res_d.m_r0c1 = entry_out(s_t'(p_t'(sysp_q) * p_t'(cr2_q)) + s_t'(p_t'(cy2_q) * p_t'(sr2_q)));
    res_d.m_r0c2 = entry_out(s_t'(p_t'(sy2_q) * p_t'(cp2_q)));
    res_d.t_out_0 = pos2_q[95:64];
    res_d.m_r1c0 = entry_out(s_t'(p_t'(cp2_q) * p_t'(sr2_q)));
    res_d.m_r1c1 = entry_out(-s_t'(p_t'(cp2_q) * p_t'(cr2_q)));
    res_d.m_r1c2 = entry_out(pos_one);
    res_d.t_out_1 = nz;
    res_d.m_r2c0 = entry_out(s_t'(p_t'(cysp_q) * p_t'(sr2_q)) + s_t'(p_t'(sy2_q) * p_t'(cr2_q)));
    res_d.m_r2c1 = entry_out(s_t'(p_t'(sy2_q) * p_t'(sr2_q)) - s_t'(p_t'(cysp_q) * p_t'(cr2_q)));
    res_d.m_r2c2 = entry_out(-s_t'(p_t'(cy2_q) * p_t'(cp2_q)));
    res_d.t_out_2 = pos2_q[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cr_q <= cr_d; sr_q <= sr_d; cp_q <= cp_d;
      sp_q <= sp_d; cy_q <= cy_d; sy_q <= sy_d;
      pos1_q <= pos_i;
      sysp_q <= rnd30(prod_ys); cysp_q <= rnd30(prod_yc);
      cr2_q <= cr_q; sr2_q <= sr_q; cp2_q <= cp_q;
      sp2_q <= sp_q; cy2_q <= cy_q; sy2_q <= sy_q;
      pos2_q <= pos1_q;
      res_q <= res_d;
    end
  end

  assign valid_o = v_q[2];
  assign res_o   = res_q;
endmodule
`default_nettype wire

### rtl/euler_to_camera_pose_matrix.sv
// Top level: Euler angles and position in, camera pose matrix and translation out.
// Usage:
//   Input channel in_valid_i / in_stall_o / in_req_i carries roll, pitch, yaw
//   (binary angles) and a Q16.16 position. Output channel out_valid_o /
//   out_stall_i / out_req_o carries nine Q1.14 rotation entries and the
//   translation (x, -z, y).
//   Every request yields one result, passing through 30 CORDIC cells in a row
//   and then three matrix stages (trig select, triple-product rounding,
//   sums). Throughput is one request per clock while the output is not stalled.
//   The whole chain advances together; while the receiver stalls with a
//   valid result at the output, the chain holds and in_stall_o is raised,
//   otherwise empty slots are filled freely.
//   Reset clears all valid bits; no clearing pass is needed.
`default_nettype none
module euler_to_camera_pose_matrix (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire e2cp_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output e2cp_pkg::out_req_t      out_req_o
);
  import e2cp_pkg::*;
`include "assert_macros.svh"

  logic adv;
  logic   vc [CordicSteps+1];
  lanes_t lc [CordicSteps+1];
  logic [95:0] pc [CordicSteps+1];
  logic [1:0] q0, q1, q2;

  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign vc[0] = in_valid_i;
  assign pc[0] = {in_req_i.pos_x, in_req_i.pos_y, in_req_i.pos_z};
  always_comb begin
    lc[0].r = rot_init(in_req_i.roll_angle, q0);
    lc[0].p = rot_init(in_req_i.pitch_angle, q1);
    lc[0].w = rot_init(in_req_i.yaw_angle, q2);
    lc[0].qr = q0; lc[0].qp = q1; lc[0].qw = q2;
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    e2cp_cell u_cell (
      .clk_i, .rst_ni,
      .step_i(5'(g)),
      .valid_i(vc[g]), .lanes_i(lc[g]), .pos_i(pc[g]), .adv_i(adv),
      .valid_o(vc[g+1]), .lanes_o(lc[g+1]), .pos_o(pc[g+1])
    );
  end

  e2cp_mat u_mat (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(vc[CordicSteps]), .lanes_i(lc[CordicSteps]), .pos_i(pc[CordicSteps]),
    .valid_o(out_valid_o), .res_o(out_req_o)
  );

  `ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `ASSERT_NXT(a_hold_valid, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NXT(a_hold_data, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_req_o))
endmodule
`default_nettype wire
